// ===== design/h3sp_pkg.sv =====
// Shared types, codes and helpers for the HTTP/3 SETTINGS payload parser.
package h3sp_pkg;

    localparam int unsigned VARINT_W  = 62;
    localparam int unsigned LIMIT_W   = 64;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned LEFT_W    = 3;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_RAW_W = VARINT_W + LIMIT_W + VARINT_W;
    localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

    localparam logic [VARINT_W-1:0] ID_CAPACITY = 62'h01;
    localparam logic [VARINT_W-1:0] ID_SECTION  = 62'h06;
    localparam logic [VARINT_W-1:0] ID_BLOCKED  = 62'h07;

    localparam logic [LIMIT_W-1:0] LIMIT_DEFAULT = '1;

    typedef enum logic [1:0] {
        SET_NONE     = 2'd0,
        SET_CAPACITY = 2'd1,
        SET_SECTION  = 2'd2,
        SET_BLOCKED  = 2'd3
    } setting_t;

    // What the varint decoder reports to the settings store for one beat.
    typedef struct packed {
        logic                pair_done;
        setting_t            kind;
        logic [VARINT_W-1:0] value;
        logic                busy;
    } vi_evt_t;

    typedef struct packed {
        logic [VARINT_W-1:0] capacity;
        logic [LIMIT_W-1:0]  section_limit;
        logic [VARINT_W-1:0] blocked;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Bytes still to come after the first byte of a varint.
    function automatic logic [LEFT_W-1:0] first_left(input logic [1:0] prefix);
        logic [LEFT_W-1:0] n;
        unique case (prefix)
            2'd0: n = 3'd0;
            2'd1: n = 3'd1;
            2'd2: n = 3'd3;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

    function automatic setting_t classify(input logic [VARINT_W-1:0] id);
        setting_t k;
        if (id == ID_CAPACITY) begin
            k = SET_CAPACITY;
        end else if (id == ID_SECTION) begin
            k = SET_SECTION;
        end else if (id == ID_BLOCKED) begin
            k = SET_BLOCKED;
        end else begin
            k = SET_NONE;
        end
        return k;
    endfunction

endpackage

// ===== design/h3sp_varint.sv =====
// Varint decoder: assembles identifier and value varints one byte per beat.
module h3sp_varint (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  logic                                 take,
    input  logic                                 last,
    input  logic [h3sp_pkg::IN_DATA_W-1:0]       data_byte,
    output h3sp_pkg::vi_evt_t                    evt
);

    logic [h3sp_pkg::VARINT_W-1:0] accum_reg;
    logic [h3sp_pkg::VARINT_W-1:0] accum_next;
    logic [h3sp_pkg::LEFT_W-1:0]   left_reg;
    logic [h3sp_pkg::LEFT_W-1:0]   left_next;
    logic                          reading_reg;
    logic                          reading_next;
    logic [h3sp_pkg::VARINT_W-1:0] pending_id_reg;
    logic [h3sp_pkg::VARINT_W-1:0] pending_id_next;
    logic [h3sp_pkg::VARINT_W-1:0] acc_byte;
    logic [h3sp_pkg::LEFT_W-1:0]   left_byte;

    always_comb begin
        if (left_reg == '0) begin
            acc_byte  = {{(h3sp_pkg::VARINT_W-6){1'b0}}, data_byte[5:0]};
            left_byte = h3sp_pkg::first_left(data_byte[7:6]);
        end else begin
            acc_byte  = {accum_reg[h3sp_pkg::VARINT_W-9:0], data_byte};
            left_byte = left_reg - 3'd1;
        end
    end

    always_comb begin
        accum_next      = accum_reg;
        left_next       = left_reg;
        reading_next    = reading_reg;
        pending_id_next = pending_id_reg;
        evt.pair_done   = 1'b0;
        evt.kind        = h3sp_pkg::classify(pending_id_reg);
        evt.value       = acc_byte;
        if (take) begin
            left_next  = left_byte;
            accum_next = acc_byte;
            if (left_byte == '0) begin
                if (!reading_reg) begin
                    pending_id_next = acc_byte;
                    reading_next    = 1'b1;
                end else begin
                    evt.pair_done = 1'b1;
                    reading_next  = 1'b0;
                end
            end
        end
        // Still inside a varint, or an identifier waits for its value.
        evt.busy = (left_next != '0) || reading_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            reading_reg <= 1'b0;
        end else if (step) begin
            if (last) begin
                left_reg    <= '0;
                reading_reg <= 1'b0;
            end else begin
                left_reg    <= left_next;
                reading_reg <= reading_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            accum_reg      <= accum_next;
            pending_id_reg <= pending_id_next;
        end
    end

endmodule

// ===== design/h3sp_store.sv =====
// Settings store: keeps known settings, detects duplicates and forms the result.
module h3sp_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                last,
    input  h3sp_pkg::vi_evt_t   evt,
    output logic                err_free,
    output h3sp_pkg::result_t   result
);

    logic [2:0]                          seen_reg;
    logic [2:0]                          seen_next;
    logic [h3sp_pkg::VARINT_W-1:0]       cap_reg;
    logic [h3sp_pkg::VARINT_W-1:0]       cap_next;
    logic [h3sp_pkg::LIMIT_W-1:0]        sect_reg;
    logic [h3sp_pkg::LIMIT_W-1:0]        sect_next;
    logic [h3sp_pkg::VARINT_W-1:0]       blk_reg;
    logic [h3sp_pkg::VARINT_W-1:0]       blk_next;
    logic [h3sp_pkg::STATUS_W-1:0]       err_reg;
    logic [h3sp_pkg::STATUS_W-1:0]       err_next;
    logic [2:0]                          bit_sel;
    logic [h3sp_pkg::STATUS_W-1:0]       status;

    assign err_free = (err_reg == h3sp_pkg::ST_OK);

    always_comb begin
        unique case (evt.kind)
            h3sp_pkg::SET_CAPACITY: bit_sel = 3'b001;
            h3sp_pkg::SET_SECTION:  bit_sel = 3'b010;
            h3sp_pkg::SET_BLOCKED:  bit_sel = 3'b100;
            default:                bit_sel = 3'b000;
        endcase
    end

    always_comb begin
        seen_next = seen_reg;
        cap_next  = cap_reg;
        sect_next = sect_reg;
        blk_next  = blk_reg;
        err_next  = err_reg;
        // pair_done is only raised on a beat that the decoder actually took.
        if (evt.pair_done && (bit_sel != 3'b000)) begin
            if ((seen_reg & bit_sel) != 3'b000) begin
                err_next = h3sp_pkg::ST_DUP;
            end else begin
                seen_next = seen_reg | bit_sel;
                unique case (evt.kind)
                    h3sp_pkg::SET_CAPACITY: cap_next = evt.value;
                    h3sp_pkg::SET_SECTION:
                        sect_next = {{(h3sp_pkg::LIMIT_W-h3sp_pkg::VARINT_W){1'b0}}, evt.value};
                    h3sp_pkg::SET_BLOCKED:  blk_next = evt.value;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        status = err_next;
        if ((err_next == h3sp_pkg::ST_OK) && evt.busy) begin
            status = h3sp_pkg::ST_TRUNC;
        end
        result.status = status;
        if (status == h3sp_pkg::ST_OK) begin
            result.capacity      = cap_next;
            result.section_limit = sect_next;
            result.blocked       = blk_next;
        end else begin
            result.capacity      = '0;
            result.section_limit = h3sp_pkg::LIMIT_DEFAULT;
            result.blocked       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            cap_reg  <= '0;
            sect_reg <= h3sp_pkg::LIMIT_DEFAULT;
            blk_reg  <= '0;
            err_reg  <= h3sp_pkg::ST_OK;
        end else if (step) begin
            if (last) begin
                seen_reg <= '0;
                cap_reg  <= '0;
                sect_reg <= h3sp_pkg::LIMIT_DEFAULT;
                blk_reg  <= '0;
                err_reg  <= h3sp_pkg::ST_OK;
            end else begin
                seen_reg <= seen_next;
                cap_reg  <= cap_next;
                sect_reg <= sect_next;
                blk_reg  <= blk_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

// ===== design/http3_settings_payload_parser.sv =====
// Top level of the HTTP/3 SETTINGS payload parser.
// A result goes to out_reg, and so to m_tdata/m_tuser, as its last beat leaves the input register.
// Throughput: one beat per cycle; the input register drains while the result waits.
// Only a last beat meeting an unread result stalls, until m_tready takes it.
// Reset (aresetn low, synchronous) empties both registers and restores the defaults.
module http3_settings_payload_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [h3sp_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] data_byte
    input  logic                              s_tuser,  // [0] byte_valid
    input  logic                              s_tlast,  // end_of_payload
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [61:0] table_capacity, [125:62] field_section_limit,
    // [187:126] blocked_streams, [191:188] zero
    output logic [h3sp_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [h3sp_pkg::STATUS_W-1:0]     m_tuser   // [1:0] status
);

    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [h3sp_pkg::IN_DATA_W-1:0]  in_byte_reg;
    logic                            in_bvalid_reg;
    logic                            in_last_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    h3sp_pkg::result_t               out_reg;
    h3sp_pkg::result_t               result;
    h3sp_pkg::vi_evt_t               evt;
    logic                            err_free;
    logic                            step;
    logic                            take;

    // A beat leaves the input register unless it is a last beat with the result slot full.
    assign step     = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign take     = step && in_bvalid_reg && err_free;
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg   <= s_tdata;
            in_bvalid_reg <= s_tuser;
            in_last_reg   <= s_tlast;
        end
        if (step && in_last_reg) begin
            out_reg <= result;
        end
    end

    h3sp_varint u_varint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .take      (take),
        .last      (in_last_reg),
        .data_byte (in_byte_reg),
        .evt       (evt)
    );

    h3sp_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .last     (in_last_reg),
        .evt      (evt),
        .err_free (err_free),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{h3sp_pkg::OUT_PAD_W{1'b0}}, out_reg.blocked,
                       out_reg.section_limit, out_reg.capacity};
    assign m_tuser  = out_reg.status;

endmodule

// ===== design/h3sp_checker.sv =====
// Port-level checks for the SETTINGS payload parser, bound to its top level.
module h3sp_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [h3sp_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic [h3sp_pkg::STATUS_W-1:0]     m_tuser
);

    // A result waiting on the master side keeps its beat unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == h3sp_pkg::ST_OK) || (m_tuser == h3sp_pkg::ST_DUP)
                     || (m_tuser == h3sp_pkg::ST_TRUNC))
        else $error("status outside its codes");

    // On any error the settings fields carry their defaults.
    a_error_defaults: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != h3sp_pkg::ST_OK) |->
            (m_tdata[61:0] == '0) && (m_tdata[125:62] == h3sp_pkg::LIMIT_DEFAULT)
            && (m_tdata[187:126] == '0))
        else $error("error result without default settings");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[h3sp_pkg::OUT_DATA_W-1:h3sp_pkg::OUT_RAW_W] == '0))
        else $error("padding bits of result not zero");

    // Straight after reset nothing is pending and the input side is open.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("parser not empty straight after reset");

endmodule

bind http3_settings_payload_parser h3sp_checker u_h3sp_checker (.*);
